@@ hw/rtl/csm_pkg.sv @@
`default_nettype none

package csm_pkg;

  // fixed field widths
  localparam int FUNC_W = 2;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int ROW_W  = 16;
  localparam int ACC_W  = 48;
  localparam int FRAC_W = 16;

  // default sizing
  localparam int VECTOR_DEPTH_DEF = 1024;
  localparam int MAX_ROWS_DEF     = 65536;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NZ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EMPTY = 2'd2;

  // scale after reset, 1.0 in q16.16
  localparam logic signed [VAL_W-1:0] SCALE_RESET = 32'sd65536;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch nonzero operands, read vector store
    logic load;     // write vector store, clear row state
    logic mul_nz;   // value times vector element
    logic acc_add;  // round product into accumulator
    logic mul_lo;   // low accumulator half times scale
    logic mul_hi;   // high accumulator half times scale
    logic emit;     // finish row into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_hold; // output register full and stalled
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/csm_ctrl.sv @@
`default_nettype none

module csm_ctrl import csm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic              in_row_end,
  output logic                   in_stall,
  input  wire sts_t              sts,
  output cmd_t                   cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_FLO  = 3'd3;
  localparam logic [2:0] ST_FHI  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       row_end_r, row_end_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    row_end_nxt = row_end_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_LOAD: cmd.load = 1'b1;
            FUNC_NZ: begin
              cmd.capture = 1'b1;
              row_end_nxt = in_row_end;
              state_nxt   = ST_MUL;
            end
            FUNC_EMPTY: state_nxt = ST_FLO;
            default: ; // unused code, item dropped
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul_nz = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = row_end_r ? ST_FLO : ST_IDLE;
      end
      ST_FLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_FHI;
      end
      ST_FHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_hold) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_end_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_end_r <= row_end_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/csm_dpath.sv @@
`default_nettype none

module csm_dpath import csm_pkg::*; #(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF,
  parameter int MAX_ROWS     = MAX_ROWS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  output sts_t                         sts,
  input  wire logic [IDX_W-1:0]        in_index,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire logic                    cfg_wr_en,
  input  wire logic signed [VAL_W-1:0] cfg_wr_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [ROW_W-1:0]             out_row,
  output logic signed [VAL_W-1:0]      out_row_value,
  output logic                         out_saturated
);

  localparam int AW    = $clog2(VECTOR_DEPTH);
  localparam int XW    = (AW > IDX_W) ? AW : IDX_W;
  localparam int CW    = $clog2(MAX_ROWS);
  localparam int RW    = (CW > ROW_W) ? CW : ROW_W;
  localparam int MW    = VAL_W + 1;
  localparam int PW    = 2 * VAL_W;
  localparam int PARTW = VAL_W + 2;
  localparam logic [CW-1:0]           CNT_LAST = CW'(MAX_ROWS - 1);
  localparam logic [PW-1:0]           HALF_LSB = PW'(1) << (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};

  // vector store
  logic signed [VAL_W-1:0] vec_mem [VECTOR_DEPTH];
  logic signed [VAL_W-1:0] rdata_r;
  logic [XW-1:0]           idx_x;
  logic [AW-1:0]           addr;
  logic                    in_range;

  assign idx_x    = XW'(in_index);
  assign addr     = idx_x[AW-1:0];
  assign in_range = (32'(in_index) < 32'(VECTOR_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.load && in_range) begin
      vec_mem[addr] <= in_value;
    end
    if (cmd.capture) begin
      rdata_r <= vec_mem[addr];
    end
  end

  // operand latch
  logic signed [VAL_W-1:0] val_r;
  logic                    in_range_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_r      <= in_value;
      in_range_r <= in_range;
    end
  end

  // row state and scale
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    clip_r, clip_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic signed [VAL_W-1:0] scale_r, scale_nxt;

  // shared multiplier
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_full;
  logic signed [PW-1:0]   prod_r, prod_nxt;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_nz) begin
      mul_a = MW'(val_r);
      mul_b = in_range_r ? MW'(rdata_r) : '0;
    end else if (cmd.mul_lo) begin
      mul_a = MW'({1'b0, acc_r[FRAC_W-1:0]});
      mul_b = MW'(scale_r);
    end else if (cmd.mul_hi) begin
      mul_a = MW'($signed(acc_r[ACC_W-1:FRAC_W]));
      mul_b = MW'(scale_r);
    end
  end

  assign mul_full = mul_a * mul_b;
  assign prod_nxt = (cmd.mul_nz || cmd.mul_lo || cmd.mul_hi) ? mul_full[PW-1:0] : prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // round half up to q16.16
  logic [PW-1:0]           prod_rnd;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W:0]   acc_sum;
  logic                    acc_ovf;
  logic signed [ACC_W-1:0] acc_sat;

  assign prod_rnd = prod_r + HALF_LSB;
  assign term     = $signed(prod_rnd[FRAC_W+ACC_W-1:FRAC_W]);
  assign acc_sum  = {acc_r[ACC_W-1], acc_r} + {term[ACC_W-1], term};
  assign acc_ovf  = acc_sum[ACC_W] ^ acc_sum[ACC_W-1];
  assign acc_sat  = acc_ovf ? (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_W-1:0];

  // low partial, rounded, held while the high partial is formed
  logic signed [PARTW-1:0] part_r, part_nxt;

  assign part_nxt = cmd.mul_hi ? $signed(prod_rnd[FRAC_W+PARTW-1:FRAC_W]) : part_r;

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
  end

  // final row value
  logic signed [PW-1:0]    row_sum;
  logic [PW-VAL_W:0]       row_top;
  logic                    row_ovf;
  logic signed [VAL_W-1:0] row_sat;

  assign row_sum = prod_r + PW'(part_r);
  assign row_top = row_sum[PW-1:VAL_W-1];
  assign row_ovf = !((&row_top) || !(|row_top));
  assign row_sat = row_ovf ? (row_sum[PW-1] ? VAL_MIN : VAL_MAX) : row_sum[VAL_W-1:0];

  always_comb begin
    acc_nxt   = acc_r;
    clip_nxt  = clip_r;
    cnt_nxt   = cnt_r;
    scale_nxt = cfg_wr_en ? cfg_wr_data : scale_r;
    if (cmd.load) begin
      acc_nxt  = '0;
      clip_nxt = 1'b0;
      cnt_nxt  = '0;
    end else if (cmd.acc_add) begin
      acc_nxt  = acc_sat;
      clip_nxt = clip_r | acc_ovf;
    end else if (cmd.emit) begin
      acc_nxt  = '0;
      clip_nxt = 1'b0;
      cnt_nxt  = (cnt_r == CNT_LAST) ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      clip_r  <= 1'b0;
      cnt_r   <= '0;
      scale_r <= SCALE_RESET;
    end else begin
      acc_r   <= acc_nxt;
      clip_r  <= clip_nxt;
      cnt_r   <= cnt_nxt;
      scale_r <= scale_nxt;
    end
  end

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]        out_row_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_sat_r;
  logic [RW-1:0]           cnt_x;

  assign cnt_x = RW'(cnt_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= cnt_x[ROW_W-1:0];
      out_value_r <= row_sat;
      out_sat_r   <= clip_r | row_ovf;
    end
  end

  assign sts.out_hold  = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_row_value = out_value_r;
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire

@@ hw/rtl/csr_sparse_matvec.sv @@
// Sparse matrix times dense vector in compressed-row form, signed q16.16 throughout.
// Load words (func 0) write one dense vector element into an on-chip store of
// VECTOR_DEPTH entries and restart at row 0 with a cleared accumulator; a load
// beyond the depth writes nothing. Nonzero words (func 1) multiply their value by
// the stored element at the given column (zero beyond the depth), round to
// q16.16 and add into a 48-bit saturating accumulator. A nonzero with row_end
// set, or an empty-row word (func 2), closes the row: the sum is multiplied by
// the scale register, rounded, clipped to 32 bits and presented with the low
// 16 bits of the row number; saturated flags a clip of the accumulator or of
// the result. Func 3 is dropped. Vector entries must be loaded before a nonzero
// reads them. The single shared 33x33 multiplier sets the steps: a load or dropped
// word is taken alone, a nonzero is multiplied then accumulated, and a row close
// forms two partial products of the 48-bit sum by the scale, then emits. The result
// sits in an output register; the block keeps taking words while it waits, and only
// stalls on closing a further row while it is still unread. The user writes the
// scale register (reset 1.0) via cfg_wr_en only while idle, unchecked by the block.
`default_nettype none

module csr_sparse_matvec import csm_pkg::*; #(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF,
  parameter int MAX_ROWS     = MAX_ROWS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input words
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [FUNC_W-1:0]       in_func,
  input  wire logic [IDX_W-1:0]        in_index,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire logic                    in_row_end,
  // finished rows
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [ROW_W-1:0]             out_row,
  output logic signed [VAL_W-1:0]      out_row_value,
  output logic                         out_saturated,
  // scale register
  input  wire logic                    cfg_wr_en,
  input  wire logic signed [VAL_W-1:0] cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: one word at a time through the multiply and row-close steps
  csm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_func    (in_func),
    .in_row_end (in_row_end),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // vector store, multiplier, accumulator, row counter and output register
  csm_dpath #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .MAX_ROWS     (MAX_ROWS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_index      (in_index),
    .in_value      (in_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_row_value (out_row_value),
    .out_saturated (out_saturated)
  );

endmodule

`default_nettype wire

@@ hw/rtl/csm_checker.sv @@
`default_nettype none

module csm_checker import csm_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic [FUNC_W-1:0]       in_func,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [ROW_W-1:0]        out_row,
  input wire logic signed [VAL_W-1:0] out_row_value,
  input wire logic                    out_saturated
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row)
      && $stable(out_row_value) && $stable(out_saturated))
    else $error("result word changed while stalled");

  // a load completes in its own cycle
  a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_LOAD |=> !in_stall)
    else $error("load word did not complete in one cycle");

  // a nonzero keeps the sequencer busy after acceptance
  a_nz_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_NZ |=> in_stall)
    else $error("nonzero word did not occupy the multiplier");

  // a new result only comes out of a busy sequence
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared without a row close");

endmodule

bind csr_sparse_matvec csm_checker u_csm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_row       (out_row),
  .out_row_value (out_row_value),
  .out_saturated (out_saturated)
);

`default_nettype wire

@@ verif/csm_checker.sv @@
`default_nettype none

module csm_scoreboard import csm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_stall,
  input  wire logic [FUNC_W-1:0]       in_func,
  input  wire logic [IDX_W-1:0]        in_index,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire logic                    in_row_end,
  input  wire logic                    out_valid,
  input  wire logic                    out_stall,
  input  wire logic [ROW_W-1:0]        out_row,
  input  wire logic signed [VAL_W-1:0] out_row_value,
  input  wire logic                    out_saturated,
  input  wire logic                    cfg_wr_en,
  input  wire logic signed [VAL_W-1:0] cfg_wr_data,
  output int                           fail_count,
  output int                           rows_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] value;
    logic                    sat;
  } row_result_t;

  localparam longint ACC_MAX = 64'sd140737488355327;
  localparam longint ACC_MIN = -ACC_MAX - 64'sd1;
  localparam longint ROW_MAX = 64'sd2147483647;
  localparam longint ROW_MIN = -64'sd2147483648;

  // shadow of the block
  logic signed [VAL_W-1:0] vec_mem [VECTOR_DEPTH_DEF];
  longint                  row_acc;
  logic                    acc_clip;
  logic [ROW_W-1:0]        row_num;
  logic signed [VAL_W-1:0] scale_q;

  row_result_t expected_rows [$];
  row_result_t exp_row;
  row_result_t new_row;

  // scale the row sum in two halves, round, clip to 32 bits
  function automatic row_result_t close_row();
    longint      hi;
    longint      lo;
    longint      r;
    row_result_t res;
    hi = row_acc >>> FRAC_W;
    lo = row_acc & 64'hFFFF;
    r = hi * scale_q + ((lo * scale_q + 64'sd32768) >>> FRAC_W);
    res.sat = acc_clip;
    if (r > ROW_MAX) begin
      r = ROW_MAX;
      res.sat = 1'b1;
    end
    if (r < ROW_MIN) begin
      r = ROW_MIN;
      res.sat = 1'b1;
    end
    res.row = row_num;
    res.value = r[VAL_W-1:0];
    row_acc = 0;
    acc_clip = 1'b0;
    row_num = row_num + 1'b1;
    return res;
  endfunction

  // returns 1 when the word closes a row
  function automatic bit apply_word(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                                    input logic signed [VAL_W-1:0] v, input logic last,
                                    output row_result_t res);
    longint elem;
    longint term;
    longint sum;
    res = '0;
    case (f)
      FUNC_LOAD: begin
        vec_mem[idx] = v;
        row_num = '0;
        row_acc = 0;
        acc_clip = 1'b0;
        return 1'b0;
      end
      FUNC_NZ: begin
        elem = vec_mem[idx];
        term = (longint'(v) * elem + 64'sd32768) >>> FRAC_W;
        sum = row_acc + term;
        if (sum > ACC_MAX) begin
          sum = ACC_MAX;
          acc_clip = 1'b1;
        end
        if (sum < ACC_MIN) begin
          sum = ACC_MIN;
          acc_clip = 1'b1;
        end
        row_acc = sum;
        if (!last) return 1'b0;
        res = close_row();
        return 1'b1;
      end
      FUNC_EMPTY: begin
        res = close_row();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      row_acc = 0;
      acc_clip = 1'b0;
      row_num = '0;
      scale_q = SCALE_RESET;
      expected_rows.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected row result row %0d value %0d sat %0b", $time,
                   out_row, out_row_value, out_saturated);
        end else begin
          exp_row = expected_rows.pop_front();
          if (out_row !== exp_row.row || out_row_value !== exp_row.value ||
              out_saturated !== exp_row.sat) begin
            fail_count++;
            $display({"%0t: row mismatch, expected row %0d value %0d sat %0b,",
                      " got row %0d value %0d sat %0b"},
                     $time, exp_row.row, exp_row.value, exp_row.sat,
                     out_row, out_row_value, out_saturated);
          end
        end
      end
      if (cfg_wr_en) scale_q = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (apply_word(in_func, in_index, in_value, in_row_end, new_row))
          expected_rows.push_back(new_row);
      end
    end
    rows_pending = expected_rows.size();
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csm_pkg::*;

  // func code the block drops without effect
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int          ITEMS        = 1550;
  localparam int          N_PHASES     = 9;
  localparam int          RANDOM_PHASE = 7;
  localparam int          SETTLE       = 16;   // plenty of margin over the worst word
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam logic [VAL_W-1:0] ONE_Q   = 32'h0001_0000;
  localparam logic [VAL_W-1:0] MONE_Q  = 32'hFFFF_0000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // block ports, all inputs known from time zero
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [FUNC_W-1:0]       in_func = FUNC_LOAD;
  logic [IDX_W-1:0]        in_index = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    in_row_end = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ROW_W-1:0]        out_row;
  logic signed [VAL_W-1:0] out_row_value;
  logic                    out_saturated;
  logic                    cfg_wr_en = 1'b0;
  logic signed [VAL_W-1:0] cfg_wr_data = '0;

  int          fail_count;
  int          rows_pending;
  int          send_pct;
  int          recv_pct;
  int          words_sent;
  int unsigned cycle_count;

  // which vector entries hold a value, nonzeros only ever read these
  bit loaded_map [VECTOR_DEPTH_DEF];
  int loaded_cols [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  csr_sparse_matvec i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_index      (in_index),
    .in_value      (in_value),
    .in_row_end    (in_row_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_row_value (out_row_value),
    .out_saturated (out_saturated),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  csm_scoreboard i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_index      (in_index),
    .in_value      (in_value),
    .in_row_end    (in_row_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_row_value (out_row_value),
    .out_saturated (out_saturated),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .rows_pending  (rows_pending)
  );

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  function automatic void set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SEND: begin send_pct = 84; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 84; end
      default:   begin send_pct = 30; recv_pct = 30; end
    endcase
  endfunction

  // mostly modest q16.16 numbers so rows stay in range, with extremes mixed in
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom();
      default: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
    endcase
  endfunction

  // scale for each phase, the extremes among them
  function automatic logic [VAL_W-1:0] scale_for_phase(input int p);
    case (p)
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0000;
      4:       return 32'h0000_0001;
      5:       return MONE_Q;
      6:       return 32'h0000_8000;
      RANDOM_PHASE: return $urandom();
      default: return ONE_Q;
    endcase
  endfunction

  // entered and left at a falling edge; valid held until the word is taken
  task automatic push_word(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] v, input logic last);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= f;
    in_index   <= idx;
    in_value   <= v;
    in_row_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f != FUNC_UNUSED) words_sent++;
    @(negedge clk);
  endtask

  task automatic load_word(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] v,
                           input logic last);
    if (!loaded_map[idx]) begin
      loaded_map[idx] = 1'b1;
      loaded_cols.push_back(idx);
    end
    push_word(FUNC_LOAD, idx, v, last);
  endtask

  // only touch the scale once nothing is in flight
  task automatic write_scale(input logic [VAL_W-1:0] v);
    in_valid <= 1'b0;
    while (rows_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic directed_words();
    // vector extremes, plus unit values for exact rows
    load_word(10'd0, 32'h7FFF_FFFF, 1'b0);
    load_word(10'd1023, 32'h8000_0000, 1'b1);   // row end on a load is ignored
    load_word(10'h155, ONE_Q, 1'b0);
    load_word(10'h2AA, MONE_Q, 1'b0);
    // simple rows, then an empty row with junk fields
    push_word(FUNC_NZ, 10'h155, 32'h0002_0000, 1'b1);
    push_word(FUNC_NZ, 10'h2AA, 32'h0001_8000, 1'b0);
    push_word(FUNC_NZ, 10'h155, 32'h0000_4000, 1'b1);
    push_word(FUNC_EMPTY, 10'h3FF, 32'h7FFF_FFFF, 1'b1);
    // dropped func code must leave the state alone
    push_word(FUNC_UNUSED, 10'h155, 32'h1234_5678, 1'b1);
    // accumulator clips high
    repeat (2) push_word(FUNC_NZ, 10'd0, 32'h7FFF_FFFF, 1'b0);
    push_word(FUNC_NZ, 10'd0, 32'h7FFF_FFFF, 1'b1);
    // most negative times itself
    push_word(FUNC_NZ, 10'd1023, 32'h8000_0000, 1'b1);
    // accumulator clips low
    repeat (2) push_word(FUNC_NZ, 10'd1023, 32'h7FFF_FFFF, 1'b0);
    push_word(FUNC_NZ, 10'd1023, 32'h7FFF_FFFF, 1'b1);
    // load in the middle of a row restarts at row 0 with a clear sum
    push_word(FUNC_NZ, 10'h155, ONE_Q, 1'b0);
    load_word(10'd5, 32'h0003_0000, 1'b0);
    push_word(FUNC_NZ, 10'd5, ONE_Q, 1'b1);
    // rounding of tiny products either side of zero
    push_word(FUNC_NZ, 10'h2AA, 32'h0000_0001, 1'b1);
    push_word(FUNC_NZ, 10'h155, 32'h0000_0001, 1'b0);
    push_word(FUNC_NZ, 10'h2AA, 32'h0000_8000, 1'b1);
    push_word(FUNC_EMPTY, 10'd0, 32'h0, 1'b0);
  endtask

  // mostly rows over loaded columns, occasional reloads, empty rows and noise
  task automatic random_word();
    int               r;
    int               n;
    logic [IDX_W-1:0] col;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      n = $urandom_range(1, 6);
      repeat (n) load_word(IDX_W'($urandom_range(0, VECTOR_DEPTH_DEF - 1)), pick_value(),
                           1'($urandom_range(0, 1)));
    end else if (r < 9) begin
      push_word(FUNC_EMPTY, IDX_W'($urandom()), $urandom(), 1'($urandom_range(0, 1)));
    end else if (r < 12) begin
      push_word(FUNC_UNUSED, IDX_W'($urandom()), $urandom(), 1'($urandom_range(0, 1)));
    end else begin
      col = IDX_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
      push_word(FUNC_NZ, col, pick_value(), ($urandom_range(0, 3) == 0));
    end
  endtask

  // main sequence: reset, phases of scale and idling, drain, verdict
  initial begin
    send_pct = 0;
    recv_pct = 0;
    words_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < N_PHASES; p++) begin
      // first phase runs on the reset scale of 1.0
      if (p != 0) write_scale(scale_for_phase(p));
      set_idling(idle_mode_t'(p % 4));
      if (p == 0) directed_words();
      while (words_sent < (p + 1) * ITEMS / N_PHASES) random_word();
    end
    in_valid <= 1'b0;
    while (rows_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // hang guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
